@@ design/afe_pkg.sv @@
package afe_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [2*WORD_BITS-1:0] prod_t;

    localparam word_t FX_ONE = word_t'(64'sd1 <<< FRAC_BITS);

    // Command codes
    localparam logic [3:0] CMD_IDENTITY  = 4'd0;
    localparam logic [3:0] CMD_LOAD_ROW  = 4'd1;
    localparam logic [3:0] CMD_READ_ROW  = 4'd2;
    localparam logic [3:0] CMD_TRANSLATE = 4'd3;
    localparam logic [3:0] CMD_SCALE     = 4'd4;
    localparam logic [3:0] CMD_ROTATE    = 4'd5;
    localparam logic [3:0] CMD_INVERSE   = 4'd6;
    localparam logic [3:0] CMD_POINT     = 4'd7;
    localparam logic [3:0] CMD_VECTOR    = 4'd8;

    // Operand file layout: inputs, doubled quaternion products, rotation
    // matrix, copy of the translation column.
    localparam int OPF_DEPTH = 25;
    localparam logic [4:0] OPF_PROD = 5'd4;
    localparam logic [4:0] OPF_ROT  = 5'd13;
    localparam logic [4:0] OPF_TCOL = 5'd22;

    typedef enum logic [1:0] {XS_ONE, XS_M, XS_IN} xsel_t;
    typedef enum logic {YS_ONE, YS_OPF} ysel_t;
    typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
    typedef enum logic [2:0] {WR_NONE, WR_M, WR_NM, WR_OPF, WR_RES} wr_sel_t;

    typedef struct packed {
        logic    capture;
        xsel_t   xsel;
        logic [3:0] xaddr;
        ysel_t   ysel;
        logic [4:0] oaddr;
        acc_op_t acc;
        wr_sel_t wsel;
        logic [4:0] waddr;
        logic    neg;
        logic    copy;
        logic    ident;
        logic    publish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_valid;
    } dp_status_t;

endpackage

@@ design/affine_transform_engine.sv @@
// Channel  | Dir | Ports                       | Contents
// s_       | in  | s_tvalid/tready/tdata/tuser | one command request with operands
// m_       | out | m_tvalid/tready/tdata       | one result (read and transform)
//
// Each request runs as a short microprogram through one shared 32x32
// multiplier and a saturating accumulator, one multiply per cycle.
// A result waits in the output register while the next request is taken;
// the finish step stalls only when a new result meets an unconsumed one.
// Synchronous active-low reset restores the identity matrix at once.
module affine_transform_engine (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a [31:0], b [63:32], c [95:64], d [127:96]
    input  logic [7:0]   s_tuser,   // command [3:0], row [5:4], zero [7:6]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // out_x, out_y, out_z, out_w from bit 0 up
);
    import afe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    word_t      out_x, out_y, out_z, out_w;

    // Sequence each request into per-cycle datapath commands.
    afe_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tuser[3:0]),
        .in_row     (s_tuser[5:4]),
        .status     (status),
        .cmd        (cmd)
    );

    // Matrix, operand file, multiplier, accumulator and output register.
    afe_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_a      (s_tdata[31:0]),
        .in_b      (s_tdata[63:32]),
        .in_c      (s_tdata[95:64]),
        .in_d      (s_tdata[127:96]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_w     (out_w)
    );

    assign m_tdata = {out_w, out_z, out_y, out_x};

endmodule

@@ design/afe_datapath.sv @@
module afe_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  afe_pkg::dp_cmd_t  cmd,
    output afe_pkg::dp_status_t status,
    input  afe_pkg::word_t    in_a,
    input  afe_pkg::word_t    in_b,
    input  afe_pkg::word_t    in_c,
    input  afe_pkg::word_t    in_d,
    output logic              out_valid,
    input  logic              out_ready,
    output afe_pkg::word_t    out_x,
    output afe_pkg::word_t    out_y,
    output afe_pkg::word_t    out_z,
    output afe_pkg::word_t    out_w
);
    import afe_pkg::*;

    localparam int QW = 2*WORD_BITS - FRAC_BITS;
    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    function automatic word_t sat_add(input word_t x, input word_t y);
        logic signed [WORD_BITS:0] s;
        s = {x[WORD_BITS-1], x} + {y[WORD_BITS-1], y};
        if (s[WORD_BITS] != s[WORD_BITS-1])
            return s[WORD_BITS] ? WMIN : WMAX;
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t sat_neg(input word_t x);
        if (x == WMIN)
            return WMAX;
        return -x;
    endfunction

    // Floor the product to the fraction point, then saturate.
    function automatic word_t fx_trunc(input prod_t p);
        logic [QW-WORD_BITS:0] top;
        top = p[2*WORD_BITS-1:WORD_BITS-1+FRAC_BITS];
        if ((&top) || !(|top))
            return p[WORD_BITS-1+FRAC_BITS:FRAC_BITS];
        return p[2*WORD_BITS-1] ? WMIN : WMAX;
    endfunction

    word_t   m_reg   [12];
    word_t   nm_reg  [12];
    word_t   opf_reg [OPF_DEPTH];
    word_t   in_reg  [4];
    word_t   res_reg [4];
    word_t   out_reg [4];
    word_t   acc_reg, acc_next;
    prod_t   prod_reg, prod_next;
    dp_cmd_t cmd2_reg;
    logic    out_valid_reg;
    word_t   x_op, y_op, f, wval;

    always_comb begin
        case (cmd.xsel)
            XS_M:    x_op = (cmd.xaddr < 4'd12) ? m_reg[cmd.xaddr] : '0;
            XS_IN:   x_op = in_reg[cmd.xaddr[1:0]];
            default: x_op = FX_ONE;
        endcase
        case (cmd.ysel)
            YS_OPF:  y_op = opf_reg[cmd.oaddr];
            default: y_op = FX_ONE;
        endcase
        prod_next = x_op * y_op;
    end

    always_comb begin
        f = fx_trunc(prod_reg);
        case (cmd2_reg.acc)
            ACC_ADD: acc_next = sat_add(acc_reg, f);
            ACC_SUB: acc_next = sat_add(acc_reg, sat_neg(f));
            default: acc_next = f;
        endcase
        wval = cmd2_reg.neg ? sat_neg(acc_next) : acc_next;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (cmd.capture) begin
            in_reg[0]  <= in_a;
            in_reg[1]  <= in_b;
            in_reg[2]  <= in_c;
            in_reg[3]  <= in_d;
            opf_reg[0] <= in_a;
            opf_reg[1] <= in_b;
            opf_reg[2] <= in_c;
            opf_reg[3] <= in_d;
        end
        case (cmd2_reg.wsel)
            WR_M:   if (cmd2_reg.waddr < 5'd12) m_reg[cmd2_reg.waddr[3:0]] <= wval;
            WR_NM:  if (cmd2_reg.waddr < 5'd12) nm_reg[cmd2_reg.waddr[3:0]] <= wval;
            WR_OPF: if (cmd2_reg.waddr < 5'(OPF_DEPTH)) opf_reg[cmd2_reg.waddr] <= wval;
            WR_RES: res_reg[cmd2_reg.waddr[1:0]] <= wval;
            default: ;
        endcase
        if (cmd2_reg.copy)
            m_reg <= nm_reg;
        if (cmd2_reg.publish)
            out_reg <= res_reg;
        if (!aresetn || cmd2_reg.ident) begin
            for (int i = 0; i < 12; i++)
                m_reg[i] <= (i % 5 == 0) ? FX_ONE : '0;
        end
        if (!aresetn) begin
            cmd2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cmd2_reg <= cmd;
            if (cmd2_reg.publish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];
    assign out_w = out_reg[3];

endmodule

@@ design/afe_ctrl.sv @@
module afe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          in_command,
    input  logic [1:0]          in_row,
    input  afe_pkg::dp_status_t status,
    output afe_pkg::dp_cmd_t    cmd
);
    import afe_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_GAP, ST_FIN} state_t;
    typedef enum logic [3:0] {
        PH_LOAD, PH_READ, PH_TRANS, PH_SCALE, PH_PROD, PH_RBLD, PH_MAC,
        PH_TCOPY, PH_TPOSE, PH_INV, PH_XFORM, PH_WLANE, PH_DONE
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [3:0] op_reg, op_next;
    logic [1:0] row_reg, row_next;
    logic [4:0] e_reg, e_next;
    logic [1:0] k_reg, k_next;
    logic [4:0] e_last;
    logic [1:0] k_last;
    logic       is_point, wants_out, wants_copy;

    // Quaternion products: operand pairs, in slot order xx yy zz xy xz yz xw yw zw.
    function automatic logic [3:0] prod_pair(input logic [3:0] idx);
        case (idx)
            4'd0:    return {2'd0, 2'd0};
            4'd1:    return {2'd1, 2'd1};
            4'd2:    return {2'd2, 2'd2};
            4'd3:    return {2'd0, 2'd1};
            4'd4:    return {2'd0, 2'd2};
            4'd5:    return {2'd1, 2'd2};
            4'd6:    return {2'd0, 2'd3};
            4'd7:    return {2'd1, 2'd3};
            default: return {2'd2, 2'd3};
        endcase
    endfunction

    // Rotation build steps: {source slot (zero means 1.0), acc op, target (zero: none)}.
    function automatic logic [11:0] rbld_step(input logic [4:0] idx);
        case (idx)
            5'd0:    return {5'd0,  ACC_LOAD, 5'd0};
            5'd1:    return {5'd5,  ACC_SUB,  5'd0};
            5'd2:    return {5'd6,  ACC_SUB,  5'd13};
            5'd3:    return {5'd7,  ACC_LOAD, 5'd0};
            5'd4:    return {5'd12, ACC_SUB,  5'd14};
            5'd5:    return {5'd8,  ACC_LOAD, 5'd0};
            5'd6:    return {5'd11, ACC_ADD,  5'd15};
            5'd7:    return {5'd7,  ACC_LOAD, 5'd0};
            5'd8:    return {5'd12, ACC_ADD,  5'd16};
            5'd9:    return {5'd0,  ACC_LOAD, 5'd0};
            5'd10:   return {5'd4,  ACC_SUB,  5'd0};
            5'd11:   return {5'd6,  ACC_SUB,  5'd17};
            5'd12:   return {5'd9,  ACC_LOAD, 5'd0};
            5'd13:   return {5'd10, ACC_SUB,  5'd18};
            5'd14:   return {5'd8,  ACC_LOAD, 5'd0};
            5'd15:   return {5'd11, ACC_SUB,  5'd19};
            5'd16:   return {5'd9,  ACC_LOAD, 5'd0};
            5'd17:   return {5'd10, ACC_ADD,  5'd20};
            5'd18:   return {5'd0,  ACC_LOAD, 5'd0};
            5'd19:   return {5'd4,  ACC_SUB,  5'd0};
            default: return {5'd5,  ACC_SUB,  5'd21};
        endcase
    endfunction

    function automatic phase_t first_phase(input logic [3:0] op);
        case (op)
            CMD_LOAD_ROW:  return PH_LOAD;
            CMD_READ_ROW:  return PH_READ;
            CMD_TRANSLATE: return PH_TRANS;
            CMD_SCALE:     return PH_SCALE;
            CMD_ROTATE:    return PH_PROD;
            CMD_INVERSE:   return PH_TCOPY;
            CMD_POINT:     return PH_XFORM;
            CMD_VECTOR:    return PH_XFORM;
            default:       return PH_DONE;
        endcase
    endfunction

    function automatic phase_t follow_phase(input phase_t ph);
        case (ph)
            PH_PROD:  return PH_RBLD;
            PH_RBLD:  return PH_MAC;
            PH_TCOPY: return PH_TPOSE;
            PH_TPOSE: return PH_INV;
            PH_XFORM: return PH_WLANE;
            default:  return PH_DONE;
        endcase
    endfunction

    assign is_point   = (op_reg == CMD_POINT);
    assign wants_out  = (op_reg == CMD_READ_ROW) || (op_reg == CMD_POINT) ||
                        (op_reg == CMD_VECTOR);
    assign wants_copy = (op_reg == CMD_ROTATE) || (op_reg == CMD_INVERSE);
    assign in_ready   = (state_reg == ST_IDLE) && aresetn;

    always_comb begin
        case (phase_reg)
            PH_LOAD, PH_READ: begin e_last = 5'd3;  k_last = 2'd0; end
            PH_TRANS:         begin e_last = 5'd2;  k_last = 2'd1; end
            PH_SCALE:         begin e_last = 5'd11; k_last = 2'd0; end
            PH_PROD:          begin e_last = 5'd8;  k_last = 2'd1; end
            PH_RBLD:          begin e_last = 5'd20; k_last = 2'd0; end
            PH_MAC:           begin e_last = 5'd11; k_last = 2'd2; end
            PH_TCOPY:         begin e_last = 5'd2;  k_last = 2'd0; end
            PH_TPOSE:         begin e_last = 5'd11; k_last = 2'd0; end
            PH_INV:           begin e_last = 5'd2;  k_last = 2'd2; end
            PH_XFORM:         begin e_last = 5'd2;  k_last = 2'd3; end
            default:          begin e_last = 5'd0;  k_last = 2'd0; end
        endcase
    end

    // Sequencing
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        op_next    = op_reg;
        row_next   = row_reg;
        e_next     = e_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next    = in_command;
                    row_next   = in_row;
                    phase_next = first_phase(in_command);
                    e_next     = '0;
                    k_next     = '0;
                    if (in_command == CMD_IDENTITY)
                        state_next = ST_FIN;
                    else if (first_phase(in_command) != PH_DONE)
                        state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (k_reg != k_last) begin
                    k_next = k_reg + 2'd1;
                end else begin
                    k_next = '0;
                    if (e_reg != e_last) begin
                        e_next = e_reg + 5'd1;
                    end else begin
                        e_next     = '0;
                        phase_next = follow_phase(phase_reg);
                        state_next = ST_GAP;
                    end
                end
            end
            ST_GAP: begin
                state_next = (phase_reg == PH_DONE) ? ST_FIN : ST_RUN;
            end
            ST_FIN: begin
                if (!(wants_out && status.out_valid))
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath command for this cycle
    always_comb begin
        logic [11:0] rb;
        logic [3:0]  pp;
        rb  = rbld_step(e_reg);
        pp  = prod_pair(e_reg[3:0]);
        cmd = '0;
        cmd.capture = (state_reg == ST_IDLE) && in_valid;
        if (state_reg == ST_RUN) begin
            case (phase_reg)
                PH_LOAD: begin
                    cmd.xsel  = XS_IN;
                    cmd.xaddr = {2'b00, e_reg[1:0]};
                    cmd.wsel  = WR_M;
                    cmd.waddr = {1'b0, row_reg, e_reg[1:0]};
                end
                PH_READ: begin
                    cmd.xsel  = XS_M;
                    cmd.xaddr = {row_reg, e_reg[1:0]};
                    cmd.wsel  = WR_RES;
                    cmd.waddr = e_reg;
                end
                PH_TRANS: begin
                    if (k_reg == 2'd0) begin
                        cmd.xsel  = XS_M;
                        cmd.xaddr = {e_reg[1:0], 2'b11};
                    end else begin
                        cmd.xsel  = XS_IN;
                        cmd.xaddr = {2'b00, e_reg[1:0]};
                        cmd.acc   = ACC_ADD;
                        cmd.wsel  = WR_M;
                        cmd.waddr = {1'b0, e_reg[1:0], 2'b11};
                    end
                end
                PH_SCALE: begin
                    cmd.xsel  = XS_M;
                    cmd.xaddr = e_reg[3:0];
                    cmd.ysel  = YS_OPF;
                    cmd.oaddr = {3'b000, e_reg[3:2]};
                    cmd.wsel  = WR_M;
                    cmd.waddr = e_reg;
                end
                PH_PROD: begin
                    cmd.xsel  = XS_IN;
                    cmd.xaddr = {2'b00, pp[3:2]};
                    cmd.ysel  = YS_OPF;
                    cmd.oaddr = {3'b000, pp[1:0]};
                    if (k_reg != 2'd0) begin
                        cmd.acc   = ACC_ADD;
                        cmd.wsel  = WR_OPF;
                        cmd.waddr = OPF_PROD + e_reg;
                    end
                end
                PH_RBLD: begin
                    cmd.xsel  = XS_ONE;
                    cmd.ysel  = (rb[11:7] == 5'd0) ? YS_ONE : YS_OPF;
                    cmd.oaddr = rb[11:7];
                    cmd.acc   = acc_op_t'(rb[6:5]);
                    if (rb[4:0] != 5'd0) begin
                        cmd.wsel  = WR_OPF;
                        cmd.waddr = rb[4:0];
                    end
                end
                PH_MAC: begin
                    cmd.xsel  = XS_M;
                    cmd.xaddr = {k_reg, e_reg[1:0]};
                    cmd.ysel  = YS_OPF;
                    cmd.oaddr = OPF_ROT + {2'b00, e_reg[3:2], 1'b0} +
                                {3'b000, e_reg[3:2]} + {3'b000, k_reg};
                    cmd.acc   = (k_reg == 2'd0) ? ACC_LOAD : ACC_ADD;
                    if (k_reg == 2'd2) begin
                        cmd.wsel  = WR_NM;
                        cmd.waddr = e_reg;
                    end
                end
                PH_TCOPY: begin
                    cmd.xsel  = XS_M;
                    cmd.xaddr = {e_reg[1:0], 2'b11};
                    cmd.wsel  = WR_OPF;
                    cmd.waddr = OPF_TCOL + e_reg;
                end
                PH_TPOSE: begin
                    // skip the translation column, filled in by the next phase
                    if (e_reg[1:0] != 2'b11) begin
                        cmd.xsel  = XS_M;
                        cmd.xaddr = {e_reg[1:0], e_reg[3:2]};
                        cmd.wsel  = WR_NM;
                        cmd.waddr = e_reg;
                    end
                end
                PH_INV: begin
                    cmd.xsel  = XS_M;
                    cmd.xaddr = {k_reg, e_reg[1:0]};
                    cmd.ysel  = YS_OPF;
                    cmd.oaddr = OPF_TCOL + {3'b000, k_reg};
                    cmd.acc   = (k_reg == 2'd0) ? ACC_LOAD : ACC_ADD;
                    if (k_reg == 2'd2) begin
                        cmd.wsel  = WR_NM;
                        cmd.waddr = {1'b0, e_reg[1:0], 2'b11};
                        cmd.neg   = 1'b1;
                    end
                end
                PH_XFORM: begin
                    cmd.xsel  = XS_M;
                    cmd.xaddr = {e_reg[1:0], k_reg};
                    cmd.ysel  = (k_reg == 2'd3 && is_point) ? YS_ONE : YS_OPF;
                    cmd.oaddr = {3'b000, k_reg};
                    cmd.acc   = (k_reg == 2'd0) ? ACC_LOAD : ACC_ADD;
                    if (k_reg == 2'd3) begin
                        cmd.wsel  = WR_RES;
                        cmd.waddr = e_reg;
                    end
                end
                PH_WLANE: begin
                    cmd.xsel  = XS_ONE;
                    cmd.ysel  = is_point ? YS_ONE : YS_OPF;
                    cmd.oaddr = 5'd3;
                    cmd.wsel  = WR_RES;
                    cmd.waddr = 5'd3;
                end
                default: ;
            endcase
        end else if (state_reg == ST_FIN && !(wants_out && status.out_valid)) begin
            cmd.copy    = wants_copy;
            cmd.ident   = (op_reg == CMD_IDENTITY);
            cmd.publish = wants_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_DONE;
            op_reg    <= '0;
            row_reg   <= '0;
            e_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            op_reg    <= op_next;
            row_reg   <= row_next;
            e_reg     <= e_next;
            k_reg     <= k_next;
        end
    end

endmodule
